[rtl/core/perspective_point_projection_assert.svh]
// Assertion macros for the perspective point projection block.
// Empty bodies when SYNTH is defined; no other dependencies.
`ifndef PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH
`ifndef SYNTH
`define PPP_ASSERT_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("ppp assertion failed");
`define PPP_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("ppp assertion failed");
`else
`define PPP_ASSERT_IMPLY(lbl, a, b)
`define PPP_ASSERT_NEXT(lbl, a, b)
`endif
`endif

[rtl/core/ppp_pkg.sv]
// Shared types and constants for the perspective point projection block.
// No dependencies.
package ppp_pkg;
  localparam int TABLE_ENTRIES_DEF = 2048;
  localparam int COORD_SHIFT       = 8;
  localparam int NUM_W             = 48;
  localparam int DEN_W             = 32;
  localparam int RECIP_SHIFT       = 23;
  localparam int IDX_W             = 15;
  localparam int CENTRE_W          = 11;
  localparam int SCREEN_W          = 17;
  localparam int CFG_IDX_W         = 8;
  localparam int N_CELLS           = NUM_W;
  localparam int LATENCY           = N_CELLS + 3;

  localparam logic [CENTRE_W-1:0] CENTER_X_RST = 11'd160;
  localparam logic [CENTRE_W-1:0] CENTER_Y_RST = 11'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 8'd0,
    REG_CENTER_Y = 8'd1
  } reg_idx_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [DEN_W-1:0] d;
  } lane_t;

  typedef struct packed {
    logic        tbl;
    logic        zneg;
    logic        qneg_x;
    logic        qneg_y;
    logic [31:0] ax;
    logic [31:0] ay;
  } side_t;
endpackage

[rtl/core/ppp_div_cell.sv]
// One restoring division step for the x and y lanes, with sideband pass-through.
// Depends on ppp_pkg.
module ppp_div_cell import ppp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_i,
  input  side_t side_i,
  input  lane_t lx_i,
  input  lane_t ly_i,
  output logic  valid_o,
  output side_t side_o,
  output lane_t lx_o,
  output lane_t ly_o
);
  function automatic lane_t step(input lane_t l);
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    lane_t          n;
    sh   = {l.rem, l.nq[NUM_W-1]};
    diff = sh - {1'b0, l.d};
    n.d  = l.d;
    n.rem = diff[DEN_W] ? sh[DEN_W-1:0] : diff[DEN_W-1:0];
    n.nq  = {l.nq[NUM_W-2:0], ~diff[DEN_W]};
    return n;
  endfunction

  logic  valid_r;
  side_t side_r;
  lane_t lx_r, ly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_i;
    lx_r   <= step(lx_i);
    ly_r   <= step(ly_i);
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign lx_o    = lx_r;
  assign ly_o    = ly_r;
endmodule

[rtl/core/perspective_point_projection.sv]
// Top level: operand prep, a chain of division cells, multiply and centre offset.
// Depends on ppp_pkg, ppp_div_cell and perspective_point_projection_assert.svh.
//
// channel   ports                         handshake
// input     start, busy, in_*             accepted when start && !busy
// result    out_valid, out_*              one-cycle strobe, cannot stall
// config    cfg_valid, cfg_ready, cfg_*   written when cfg_valid && cfg_ready
//
// One point enters per cycle; busy is never raised.
// Pipeline stages: one prep stage, 48 division cells, multiply, offset.
// The division cells give one quotient bit each; that chain sets the latency.
// Reset clears the valid bits and restores the centres.
`include "perspective_point_projection_assert.svh"
module perspective_point_projection import ppp_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         in_point_x,
  input  logic signed [31:0]         in_point_y,
  input  logic signed [31:0]         in_point_z,
  input  logic                       in_use_reciprocal_table,
  output logic                       out_valid,
  output logic signed [SCREEN_W-1:0] out_screen_x,
  output logic signed [SCREEN_W-1:0] out_screen_y,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CENTRE_W-1:0]        cfg_data
);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_ENTRIES - 1);

  logic [CENTRE_W-1:0] center_x_r, center_y_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x_r <= cfg_data;
        REG_CENTER_Y: center_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand prep
  logic        accept;
  logic [31:0] ax, ay, az, ny, max_, may, dz;
  logic [IDX_W-1:0] v, idx;
  logic [DEN_W-1:0] d_tbl;
  side_t side_nxt;
  lane_t lx_nxt, ly_nxt;

  always_comb begin
    accept = start && !busy;
    ny   = 32'd0 - in_point_y;
    ax   = in_point_x << COORD_SHIFT;
    ay   = ny << COORD_SHIFT;
    az   = in_point_z[31] ? (32'd0 - in_point_z) : in_point_z;
    max_ = ax[31] ? (32'd0 - ax) : ax;
    may  = ay[31] ? (32'd0 - ay) : ay;
    dz   = (az == 32'd0) ? 32'd1 : az;
    v    = az[23:9];
    if (az[24]) begin
      idx = '0;
    end else if (v > IDX_MAX) begin
      idx = IDX_MAX;
    end else begin
      idx = v;
    end
    d_tbl = DEN_W'(idx) + DEN_W'(1);
    side_nxt.tbl    = in_use_reciprocal_table;
    side_nxt.zneg   = in_point_z[31];
    side_nxt.qneg_x = ax[31] ^ in_point_z[31];
    side_nxt.qneg_y = ay[31] ^ in_point_z[31];
    side_nxt.ax     = ax;
    side_nxt.ay     = ay;
    lx_nxt.rem = '0;
    ly_nxt.rem = '0;
    if (in_use_reciprocal_table) begin
      lx_nxt.nq = NUM_W'(1) << RECIP_SHIFT;
      lx_nxt.d  = d_tbl;
      ly_nxt.nq = NUM_W'(1) << RECIP_SHIFT;
      ly_nxt.d  = d_tbl;
    end else begin
      lx_nxt.nq = {max_, 16'd0};
      lx_nxt.d  = dz;
      ly_nxt.nq = {may, 16'd0};
      ly_nxt.d  = dz;
    end
  end

  logic  vc   [0:N_CELLS];
  side_t sc   [0:N_CELLS];
  lane_t lxc  [0:N_CELLS];
  lane_t lyc  [0:N_CELLS];

  logic  f_valid_r;
  side_t f_side_r;
  lane_t f_lx_r, f_ly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    f_side_r <= side_nxt;
    f_lx_r   <= lx_nxt;
    f_ly_r   <= ly_nxt;
  end

  assign vc[0]  = f_valid_r;
  assign sc[0]  = f_side_r;
  assign lxc[0] = f_lx_r;
  assign lyc[0] = f_ly_r;

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    ppp_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (vc[k]),
      .side_i  (sc[k]),
      .lx_i    (lxc[k]),
      .ly_i    (lyc[k]),
      .valid_o (vc[k+1]),
      .side_o  (sc[k+1]),
      .lx_o    (lxc[k+1]),
      .ly_o    (lyc[k+1])
    );
  end

  // multiply / select stage
  side_t       es;
  logic [NUM_W-1:0] qx, qy;
  logic [31:0] rs;
  logic signed [63:0] px, py;
  logic [15:0] hx_nxt, hy_nxt;
  logic        m_valid_r;
  logic [15:0] hx_r, hy_r;

  always_comb begin
    es = sc[N_CELLS];
    qx = es.qneg_x ? (NUM_W'(0) - lxc[N_CELLS].nq) : lxc[N_CELLS].nq;
    qy = es.qneg_y ? (NUM_W'(0) - lyc[N_CELLS].nq) : lyc[N_CELLS].nq;
    rs = es.zneg ? (32'd0 - lxc[N_CELLS].nq[31:0]) : lxc[N_CELLS].nq[31:0];
    px = $signed(es.ax) * $signed(rs);
    py = $signed(es.ay) * $signed(rs);
    hx_nxt = es.tbl ? px[47:32] : qx[31:16];
    hy_nxt = es.tbl ? py[47:32] : qy[31:16];
  end

  logic                out_valid_r;
  logic [SCREEN_W-1:0] sx_r, sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      m_valid_r   <= vc[N_CELLS];
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    hx_r <= hx_nxt;
    hy_r <= hy_nxt;
    sx_r <= {hx_r[15], hx_r} + {6'd0, center_x_r};
    sy_r <= {hy_r[15], hy_r} + {6'd0, center_y_r};
  end

  assign out_valid    = out_valid_r;
  assign out_screen_x = $signed(sx_r);
  assign out_screen_y = $signed(sy_r);

  `PPP_ASSERT_IMPLY(a_latency, out_valid, $past(start && !busy, LATENCY))
  `PPP_ASSERT_IMPLY(a_recip_range, vc[N_CELLS] && sc[N_CELLS].tbl, lxc[N_CELLS].nq[NUM_W-1:RECIP_SHIFT+1] == '0)
  `PPP_ASSERT_NEXT(a_mul_follow, vc[N_CELLS], m_valid_r && out_valid == $past(m_valid_r))
endmodule
